// ===== sv/weno5_upwind_derivative_macros.svh =====
// ----------------------------------------------------------------------------
// WENO5 upwind derivative: assertion macros
// Concurrent assertion wrappers clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef WENO5_UPWIND_DERIVATIVE_MACROS_SVH
`define WENO5_UPWIND_DERIVATIVE_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every rising clock edge outside reset.
`define W5_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("weno5 assertion failed");

// The property must never hold at a rising clock edge outside reset.
`define W5_ASSERT_NEVER(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("weno5 forbidden condition seen");

`else

`define W5_ASSERT(lbl, prop)
`define W5_ASSERT_NEVER(lbl, prop)

`endif

`endif

// ===== sv/w5ud_pkg.sv =====
// ----------------------------------------------------------------------------
// WENO5 upwind derivative package
// Shared types, register indexes, fixed-point constants and pipeline latencies.
// ----------------------------------------------------------------------------
`default_nettype none

package w5ud_pkg;

  // Q16.16 scaled difference and derivative
  typedef logic signed [31:0] fix_t;

  // Control bits that travel with each beat through a lane
  typedef struct packed {
    logic vld;
    logic act;
  } lane_ctl_t;

  // Configuration register indexes
  localparam logic [1:0] REG_MODE_SELECT    = 2'd0;
  localparam logic [1:0] REG_TUBE_HALFWIDTH = 2'd1;
  localparam logic [1:0] REG_INV_SPACING_X  = 2'd2;
  localparam logic [1:0] REG_INV_SPACING_Y  = 2'd3;

  // Configuration reset values
  localparam logic        RST_MODE_SELECT    = 1'b0;
  localparam logic [22:0] RST_TUBE_HALFWIDTH = 23'd6554;
  localparam logic [23:0] RST_INV_SPACING    = 24'd4096;

  // 12 * eps in Q.24, with eps = 1e-6 rounded to 17
  localparam int unsigned EPS_TERM = 204;

  // Quotient widths of the two divider pipelines
  localparam int unsigned RDIV_Q = 31;
  localparam int unsigned WDIV_Q = 25;

  // Register stages in one lane and from the input pins to the result pins
  localparam int unsigned LANE_LAT = 12 + RDIV_Q + WDIV_Q;
  localparam int unsigned TOP_LAT  = 3 + LANE_LAT + 1;

  // Reciprocal of three, exact for dividends below 2^33 after a shift by 35
  localparam logic [33:0] RECIP3  = 34'd11453246123;
  localparam int unsigned RECIP3_SH = 35;

endpackage

`default_nettype wire

// ===== sv/w5ud_div.sv =====
// ----------------------------------------------------------------------------
// WENO5 restoring divider pipeline
// Unsigned floor division, one quotient bit per register stage. The caller
// guarantees that the quotient fits in Q_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module w5ud_div #(
  parameter int unsigned NUM_W = 63,
  parameter int unsigned DEN_W = 63,
  parameter int unsigned Q_W   = 31
) (
  input  logic             clk_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]   quo_o
);

  // Stage outputs: partial remainder, divisor, dividend bits still to enter, quotient
  logic [DEN_W-1:0] rem_q [Q_W];
  logic [DEN_W-1:0] den_q [Q_W];
  logic [Q_W-1:0]   low_q [Q_W];
  logic [Q_W-1:0]   quo_q [Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   low_in;
    logic [Q_W-1:0]   quo_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    // The first stage starts from the high dividend bits, which lie below the divisor.
    if (j == 0) begin : g_first
      assign rem_in = DEN_W'(num_i >> Q_W);
      assign den_in = den_i;
      assign low_in = num_i[Q_W-1:0];
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign low_in = low_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    // Bring in one dividend bit and subtract the divisor when it fits.
    always_comb begin
      trial = {rem_in, low_in[Q_W-1]};
      diff  = trial - {1'b0, den_in};
      ge    = (trial >= {1'b0, den_in});
    end

    always_ff @(posedge clk_i) begin
      rem_q[j] <= ge ? DEN_W'(diff) : DEN_W'(trial);
      den_q[j] <= den_in;
      low_q[j] <= low_in << 1;
      quo_q[j] <= {quo_in[Q_W-2:0], ge};
    end
  end

  assign quo_o = quo_q[Q_W-1];

endmodule

`default_nettype wire

// ===== sv/w5ud_lane.sv =====
// ----------------------------------------------------------------------------
// WENO5 blend lane
// Turns five Q16.16 differences into the WENO5 derivative: smoothness
// indicators, nonlinear weights through two divider pipelines, and the blend.
// ----------------------------------------------------------------------------
`default_nettype none

module w5ud_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  w5ud_pkg::lane_ctl_t ctl_i,
  input  w5ud_pkg::fix_t      v_i [5],
  output w5ud_pkg::lane_ctl_t ctl_o,
  output w5ud_pkg::fix_t      deriv_o
);

  import w5ud_pkg::*;

  // Candidate numerators must wait for the weights: through the indicator
  // stages, both dividers and the square and ideal-weight stages.
  localparam int unsigned N_SR = 6 + RDIV_Q + 2 + WDIV_Q;

  // Rounded magnitude of an indicator term, Q.16 to Q.12, half up.
  function automatic logic [30:0] mag_rnd(input logic signed [39:0] x);
    logic [39:0] m;
    m = x[39] ? 40'(-x) : 40'(x);
    return 31'((m + 40'd8) >> 4);
  endfunction

  // Control shift line, one entry per register stage of the lane.
  lane_ctl_t ctl_sr_q [LANE_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LANE_LAT; i++) ctl_sr_q[i] <= '0;
    end else begin
      ctl_sr_q[0] <= ctl_i;
      for (int i = 1; i < LANE_LAT; i++) ctl_sr_q[i] <= ctl_sr_q[i-1];
    end
  end

  assign ctl_o = ctl_sr_q[LANE_LAT-1];

  // Stage 1: indicator terms and candidate numerators.
  logic signed [39:0] ve [5];
  logic signed [39:0] p_d [3];
  logic signed [39:0] q_d [3];
  logic signed [39:0] n_d [3];
  logic [30:0]        pa_q [3];
  logic [30:0]        qa_q [3];

  always_comb begin
    for (int k = 0; k < 5; k++) ve[k] = 40'(v_i[k]);
    p_d[0] = ve[0] - 2 * ve[1] + ve[2];
    q_d[0] = ve[0] - 4 * ve[1] + 3 * ve[2];
    p_d[1] = ve[1] - 2 * ve[2] + ve[3];
    q_d[1] = ve[1] - ve[3];
    p_d[2] = ve[2] - 2 * ve[3] + ve[4];
    q_d[2] = 3 * ve[2] - 4 * ve[3] + ve[4];
    n_d[0] = 2 * ve[0] - 7 * ve[1] + 11 * ve[2];
    n_d[1] = -ve[1] + 5 * ve[2] + 2 * ve[3];
    n_d[2] = 2 * ve[2] + 5 * ve[3] - ve[4];
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      pa_q[k] <= mag_rnd(p_d[k]);
      qa_q[k] <= mag_rnd(q_d[k]);
    end
  end

  // Numerator delay line, three candidates packed per entry.
  logic [110:0] nd_sr_q [N_SR];

  always_ff @(posedge clk_i) begin
    nd_sr_q[0] <= {n_d[2][36:0], n_d[1][36:0], n_d[0][36:0]};
    for (int i = 1; i < N_SR; i++) nd_sr_q[i] <= nd_sr_q[i-1];
  end

  // Stage 2: squares.
  logic [61:0] psq_q [3];
  logic [61:0] qsq_q [3];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      psq_q[k] <= pa_q[k] * pa_q[k];
      qsq_q[k] <= qa_q[k] * qa_q[k];
    end
  end

  // Stage 3: T = 12 * (IS + eps) in Q.24.
  logic [62:0] t_q [3];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      t_q[k] <= 63'(psq_q[k]) * 63'(13) + 63'(qsq_q[k]) * 63'(3) + 63'(EPS_TERM);
    end
  end

  // Stage 4: smallest indicator.
  logic [62:0] tmin_d;
  logic [62:0] tmin_q;
  logic [62:0] t4_q [3];

  always_comb begin
    tmin_d = t_q[0];
    if (t_q[1] < tmin_d) tmin_d = t_q[1];
    if (t_q[2] < tmin_d) tmin_d = t_q[2];
  end

  always_ff @(posedge clk_i) begin
    tmin_q <= tmin_d;
    t4_q   <= t_q;
  end

  // Stage 5: common right shift that brings the smallest indicator below 2^33.
  logic [4:0]  sh_d;
  logic [4:0]  sh_q;
  logic [62:0] tmin5_q;
  logic [62:0] t5_q [3];

  always_comb begin
    sh_d = '0;
    for (int i = 33; i < 63; i++) begin
      if (tmin_q[i]) sh_d = 5'(i - 32);
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q    <= sh_d;
    tmin5_q <= tmin_q;
    t5_q    <= t4_q;
  end

  // Stage 6: apply the shift.
  logic [32:0] tmin_s_q;
  logic [62:0] ts_q [3];

  always_ff @(posedge clk_i) begin
    tmin_s_q <= 33'(tmin5_q >> sh_q);
    for (int k = 0; k < 3; k++) ts_q[k] <= t5_q[k] >> sh_q;
  end

  // Ratio r_k = Tmin * 2^30 / T_k, at most 2^30.
  logic [RDIV_Q-1:0] r_w [3];

  for (genvar k = 0; k < 3; k++) begin : g_rdiv
    w5ud_div #(
      .NUM_W (63),
      .DEN_W (63),
      .Q_W   (RDIV_Q)
    ) u_rdiv (
      .clk_i (clk_i),
      .num_i ({tmin_s_q[32:0], 30'd0}),
      .den_i (ts_q[k]),
      .quo_o (r_w[k])
    );
  end

  // Squared ratio scaled back to Q.30.
  logic [61:0] rr_d [3];
  logic [30:0] rsq_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) rr_d[k] = r_w[k] * r_w[k];
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) rsq_q[k] <= 31'(rr_d[k] >> 30);
  end

  // Unnormalized weights with ideal weights 1, 6, 3, and their sum.
  logic [32:0] a_q [3];
  logic [33:0] asum_q;
  logic [32:0] a_d [3];

  always_comb begin
    a_d[0] = 33'(rsq_q[0]);
    a_d[1] = (33'(rsq_q[1]) << 2) + (33'(rsq_q[1]) << 1);
    a_d[2] = (33'(rsq_q[2]) << 1) + 33'(rsq_q[2]);
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    asum_q <= 34'(a_d[0]) + 34'(a_d[1]) + 34'(a_d[2]);
  end

  // Normalized weights in Q0.24.
  logic [WDIV_Q-1:0] w_w [3];

  for (genvar k = 0; k < 3; k++) begin : g_wdiv
    w5ud_div #(
      .NUM_W (57),
      .DEN_W (34),
      .Q_W   (WDIV_Q)
    ) u_wdiv (
      .clk_i (clk_i),
      .num_i ({a_q[k], 24'd0}),
      .den_i (asum_q),
      .quo_o (w_w[k])
    );
  end

  // Weighted candidates.
  logic signed [36:0] n_al [3];
  logic signed [62:0] prod_q [3];

  always_comb begin
    n_al[0] = $signed(nd_sr_q[N_SR-1][36:0]);
    n_al[1] = $signed(nd_sr_q[N_SR-1][73:37]);
    n_al[2] = $signed(nd_sr_q[N_SR-1][110:74]);
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) prod_q[k] <= $signed({1'b0, w_w[k]}) * n_al[k];
  end

  // Blend sum.
  logic signed [63:0] acc_q;

  always_ff @(posedge clk_i) begin
    acc_q <= 64'(prod_q[0]) + 64'(prod_q[1]) + 64'(prod_q[2]);
  end

  // Divide by 6 * 2^24 with rounding: first the power of two, then three.
  logic [63:0] mag_d;
  logic [38:0] y_d;
  logic [32:0] y_q;
  logic        big_q;
  logic        neg_q;

  always_comb begin
    mag_d = acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
    y_d   = 39'((mag_d + (64'd3 << 24)) >> 25);
  end

  always_ff @(posedge clk_i) begin
    y_q   <= 33'(y_d);
    big_q <= (y_d >= (39'd3 << 31));
    neg_q <= acc_q[63];
  end

  // Final quotient, sign and saturation.
  logic [66:0] yq_d;
  logic [31:0] q3_d;
  fix_t        res_d;
  fix_t        res_q;

  always_comb begin
    yq_d = y_q * RECIP3;
    q3_d = 32'(yq_d >> RECIP3_SH);
    priority if (big_q) begin
      res_d = neg_q ? fix_t'(32'h8000_0000) : fix_t'(32'h7FFF_FFFF);
    end else begin
      res_d = neg_q ? fix_t'(-q3_d) : fix_t'(q3_d);
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign deriv_o = res_q;

endmodule

`default_nettype wire

// ===== sv/weno5_upwind_derivative.sv =====
// ----------------------------------------------------------------------------
// WENO5 upwind derivative
// Scaled one-sided differences of a seven-sample stencil, then two WENO5
// blend lanes giving the upwind or the left- and right-biased derivative.
// ----------------------------------------------------------------------------
//  channel   handshake           payload
//  input     start, busy         axis, samp_m3..samp_p3, velocity_nonneg,
//                                tube_level, in_range
//  result    done_o              deriv_first, deriv_second, node_active
//  config    cfg_we_i            cfg_idx_i, cfg_wdata_i
//
//  One beat is taken every cycle; busy stays low.
//  Each blend lane holds two restoring divider pipelines (31 and 25
//  stages) on the path from an input beat to its result.
//  Reset clears all valid bits and loads the register reset values.
//  The result side cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
`default_nettype none
`include "weno5_upwind_derivative_macros.svh"

module weno5_upwind_derivative #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [23:0]                   cfg_wdata_i,
  input  logic                          start,
  output logic                          busy,
  input  logic                          axis_i,
  input  logic signed [SAMPLE_BITS-1:0] samp_m3_i,
  input  logic signed [SAMPLE_BITS-1:0] samp_m2_i,
  input  logic signed [SAMPLE_BITS-1:0] samp_m1_i,
  input  logic signed [SAMPLE_BITS-1:0] samp_c0_i,
  input  logic signed [SAMPLE_BITS-1:0] samp_p1_i,
  input  logic signed [SAMPLE_BITS-1:0] samp_p2_i,
  input  logic signed [SAMPLE_BITS-1:0] samp_p3_i,
  input  logic                          velocity_nonneg_i,
  input  logic [22:0]                   tube_level_i,
  input  logic                          in_range_i,
  output logic                          done_o,
  output w5ud_pkg::fix_t                deriv_first_o,
  output w5ud_pkg::fix_t                deriv_second_o,
  output logic                          node_active_o
);

  import w5ud_pkg::*;

  localparam int unsigned SB   = SAMPLE_BITS;
  localparam int unsigned PR_W = SB + 26;

  // Configuration registers
  logic        mode_q;
  logic [22:0] halfwidth_q;
  logic [23:0] invx_q;
  logic [23:0] invy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= RST_MODE_SELECT;
      halfwidth_q <= RST_TUBE_HALFWIDTH;
      invx_q      <= RST_INV_SPACING;
      invy_q      <= RST_INV_SPACING;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MODE_SELECT:    mode_q      <= cfg_wdata_i[0];
        REG_TUBE_HALFWIDTH: halfwidth_q <= cfg_wdata_i[22:0];
        REG_INV_SPACING_X:  invx_q      <= cfg_wdata_i;
        REG_INV_SPACING_Y:  invy_q      <= cfg_wdata_i;
        default:            mode_q      <= mode_q;
      endcase
    end
  end

  // The pipeline always advances.
  assign busy = 1'b0;

  // Stage 1: tube test, spacing select and raw differences.
  logic signed [SB-1:0] samp [7];
  logic signed [SB:0]   diff_d [6];
  logic signed [SB:0]   diff_q [6];
  logic [23:0]          inv_q;
  logic                 vld0_q, act0_q, vel0_q;

  always_comb begin
    samp[0] = samp_m3_i;
    samp[1] = samp_m2_i;
    samp[2] = samp_m1_i;
    samp[3] = samp_c0_i;
    samp[4] = samp_p1_i;
    samp[5] = samp_p2_i;
    samp[6] = samp_p3_i;
    for (int k = 0; k < 6; k++) diff_d[k] = (SB+1)'(samp[k+1]) - (SB+1)'(samp[k]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else begin
      vld0_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    inv_q  <= axis_i ? invy_q : invx_q;
    act0_q <= in_range_i && (tube_level_i < halfwidth_q);
    vel0_q <= velocity_nonneg_i;
  end

  // Stage 2: scale by the reciprocal spacing.
  logic signed [PR_W-1:0] prod_q [6];
  logic                   vld1_q, act1_q, vel1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else begin
      vld1_q <= vld0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 6; k++) prod_q[k] <= diff_q[k] * $signed({1'b0, inv_q});
    act1_q <= act0_q;
    vel1_q <= vel0_q;
  end

  // Stage 3: round to Q16.16, ties away from zero, and saturate.
  logic [PR_W-1:0] mag_d [6];
  logic [63:0]     rnd_d [6];
  fix_t            e_d [6];
  fix_t            e_q [6];
  logic            vld2_q, act2_q, vel2_q;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      mag_d[k] = prod_q[k][PR_W-1] ? PR_W'(-prod_q[k]) : PR_W'(prod_q[k]);
      rnd_d[k] = 64'((mag_d[k] + PR_W'(2048)) >> 12);
      if (prod_q[k][PR_W-1]) begin
        e_d[k] = (rnd_d[k] > 64'h8000_0000) ? fix_t'(32'h8000_0000)
                                            : fix_t'(-(32'(rnd_d[k])));
      end else begin
        e_d[k] = (rnd_d[k] > 64'h7FFF_FFFF) ? fix_t'(32'h7FFF_FFFF)
                                            : fix_t'(32'(rnd_d[k]));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else begin
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q    <= e_d;
    act2_q <= act1_q;
    vel2_q <= vel1_q;
  end

  // Lane A takes the left-biased stencil unless level-set mode asks for the right one.
  // Lane B always takes the right-biased stencil and is live only in reinit mode.
  logic      sel_left;
  fix_t      va [5];
  fix_t      vb [5];
  lane_ctl_t ctl_a_in, ctl_b_in, ctl_a, ctl_b;
  fix_t      deriv_a, deriv_b;

  always_comb begin
    sel_left = mode_q || vel2_q;
    for (int k = 0; k < 5; k++) begin
      va[k] = sel_left ? e_q[k] : e_q[5-k];
      vb[k] = e_q[5-k];
    end
    ctl_a_in = '{vld: vld2_q, act: act2_q};
    ctl_b_in = '{vld: vld2_q, act: act2_q && mode_q};
  end

  w5ud_lane u_lane_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_a_in),
    .v_i     (va),
    .ctl_o   (ctl_a),
    .deriv_o (deriv_a)
  );

  w5ud_lane u_lane_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_b_in),
    .v_i     (vb),
    .ctl_o   (ctl_b),
    .deriv_o (deriv_b)
  );

  // Result register: inactive nodes give zero.
  logic done_q, active_q;
  fix_t first_q, second_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q   <= 1'b0;
      active_q <= 1'b0;
    end else begin
      done_q   <= ctl_a.vld;
      active_q <= ctl_a.vld && ctl_a.act;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q  <= ctl_a.act ? deriv_a : '0;
    second_q <= ctl_b.act ? deriv_b : '0;
  end

  assign done_o         = done_q;
  assign node_active_o  = active_q;
  assign deriv_first_o  = first_q;
  assign deriv_second_o = second_q;

  // Both lanes carry the same beats in lockstep.
  `W5_ASSERT(a_lane_lockstep, ctl_a.vld == ctl_b.vld)
  // Every result beat comes from an input beat a fixed latency earlier.
  `W5_ASSERT(a_fixed_latency, done_o |-> $past(start, TOP_LAT))
  // The second lane never reports an active node the first lane drops.
  `W5_ASSERT_NEVER(a_b_without_a, ctl_b.act && ctl_b.vld && !ctl_a.act)
  // The active flag only rides on a result beat.
  `W5_ASSERT_NEVER(a_active_no_beat, node_active_o && !done_o)

endmodule

`default_nettype wire

// ===== dv/weno5_upwind_derivative_tb.sv =====
// ----------------------------------------------------------------------------
// WENO5 upwind derivative testbench
// Drives stencil beats through the command port and checks every result
// against a bit-exact fixed-point WENO5 predictor kept in a scoreboard class.
// ----------------------------------------------------------------------------
`default_nettype none

module weno5_upwind_derivative_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import w5ud_pkg::*;

  typedef struct {
    logic [31:0] first;
    logic [31:0] second;
    logic        active;
  } deriv_res_t;

  // Predicts derivatives from stencil beats and compares them with results.
  class deriv_scoreboard;
    logic        mode;
    logic [22:0] halfwidth;
    logic [23:0] inv_x;
    logic [23:0] inv_y;
    deriv_res_t  pending[$];
    int          errors;

    function void set_reg(logic [1:0] idx, logic [23:0] val);
      case (idx)
        REG_MODE_SELECT: begin
          mode = val[0];
        end
        REG_TUBE_HALFWIDTH: begin
          halfwidth = val[22:0];
        end
        REG_INV_SPACING_X: begin
          inv_x = val;
        end
        default: begin
          inv_y = val;
        end
      endcase
    endfunction

    function longint sat_q16(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    // Divide with rounding to nearest, ties away from zero.
    function longint round_div(longint x, longint d);
      longint m;
      m = ((x < 0 ? -x : x) + d / 2) / d;
      return x < 0 ? -m : m;
    endfunction

    function longint unsigned smooth_term(longint p, longint q);
      longint unsigned pa, qa;
      pa = ((p < 0 ? -p : p) + 8) >> 4;
      qa = ((q < 0 ? -q : q) + 8) >> 4;
      return 13 * pa * pa + 3 * qa * qa + 12 * 17;
    endfunction

    function longint blend(longint v[5]);
      longint unsigned t[3], a[3], w[3], tmin, sum, r;
      longint n1, n2, n3, acc;
      int sh;
      t[0] = smooth_term(v[0] - 2 * v[1] + v[2], v[0] - 4 * v[1] + 3 * v[2]);
      t[1] = smooth_term(v[1] - 2 * v[2] + v[3], v[1] - v[3]);
      t[2] = smooth_term(v[2] - 2 * v[3] + v[4], 3 * v[2] - 4 * v[3] + v[4]);
      tmin = t[0];
      if (t[1] < tmin) tmin = t[1];
      if (t[2] < tmin) tmin = t[2];
      sh = 0;
      while ((tmin >> sh) >= (64'd1 << 33)) sh++;
      sum = 0;
      for (int k = 0; k < 3; k++) begin
        r = ((tmin >> sh) << 30) / (t[k] >> sh);
        a[k] = ((k == 0) ? 1 : (k == 1) ? 6 : 3) * ((r * r) >> 30);
        sum += a[k];
      end
      for (int k = 0; k < 3; k++) w[k] = (a[k] << 24) / sum;
      n1 = 2 * v[0] - 7 * v[1] + 11 * v[2];
      n2 = -v[1] + 5 * v[2] + 2 * v[3];
      n3 = 2 * v[2] + 5 * v[3] - v[4];
      acc = longint'(w[0]) * n1 + longint'(w[1]) * n2 + longint'(w[2]) * n3;
      return sat_q16(round_div(acc, 64'd6 << 24));
    endfunction

    function void note_beat(logic ax, logic signed [23:0] s[7], logic vpos,
                            logic [22:0] level, logic rng);
      deriv_res_t r;
      longint d[6], lft[5], rgt[5], inv;
      r.first = '0;
      r.second = '0;
      r.active = rng && (level < halfwidth);
      if (r.active) begin
        inv = ax ? longint'(inv_y) : longint'(inv_x);
        for (int k = 0; k < 6; k++)
          d[k] = sat_q16(round_div((longint'(s[k + 1]) - longint'(s[k])) * inv, 4096));
        for (int k = 0; k < 5; k++) begin
          lft[k] = d[k];
          rgt[k] = d[5 - k];
        end
        if (!mode) begin
          if (vpos) r.first = 32'(blend(lft));
          else r.first = 32'(blend(rgt));
        end else begin
          r.first = 32'(blend(lft));
          r.second = 32'(blend(rgt));
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [31:0] f, logic [31:0] s, logic act);
      deriv_res_t e;
      if (pending.size() == 0) begin
        $error("unexpected result beat");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (f !== e.first) begin
        $error("deriv_first expected %0h actual %0h", e.first, f);
        errors++;
      end
      if (s !== e.second) begin
        $error("deriv_second expected %0h actual %0h", e.second, s);
        errors++;
      end
      if (act !== e.active) begin
        $error("node_active expected %0b actual %0b", e.active, act);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_idx_i = '0;
  logic [23:0]         cfg_wdata_i = '0;
  logic                start = 1'b0;
  logic                busy;
  logic                axis_i = 1'b0;
  logic signed [23:0]  samp_m3_i = '0, samp_m2_i = '0, samp_m1_i = '0, samp_c0_i = '0;
  logic signed [23:0]  samp_p1_i = '0, samp_p2_i = '0, samp_p3_i = '0;
  logic                velocity_nonneg_i = 1'b0;
  logic [22:0]         tube_level_i = '0;
  logic                in_range_i = 1'b0;
  logic                done_o;
  fix_t                deriv_first_o, deriv_second_o;
  logic                node_active_o;

  deriv_scoreboard sb;
  int              idle_pct = 24;

  weno5_upwind_derivative DUT (.*);

  always #10 clk_i = ~clk_i;

  // Check every result beat at the edge that ends its cycle.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(deriv_first_o, deriv_second_o, node_active_o);
  end

  // One register write; the enable drops for a full cycle before the next one.
  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Stop sending, wait until all results are in, then let the pipeline run empty.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (TOP_LAT + 4) @(negedge clk_i);
  endtask

  // Present one stencil beat and hold it until accepted. Start stays high
  // afterwards so that the next beat can follow without a gap.
  task automatic send_beat(logic ax, logic signed [23:0] s[7], logic vpos,
                           logic [22:0] level, logic rng);
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    axis_i <= ax;
    samp_m3_i <= s[0]; samp_m2_i <= s[1]; samp_m1_i <= s[2]; samp_c0_i <= s[3];
    samp_p1_i <= s[4]; samp_p2_i <= s[5]; samp_p3_i <= s[6];
    velocity_nonneg_i <= vpos;
    tube_level_i <= level;
    in_range_i <= rng;
    do @(posedge clk_i); while (busy);
    sb.note_beat(ax, s, vpos, level, rng);
    @(negedge clk_i);
  endtask

  // Random stencil: mostly smooth quadratics with small noise, the rest full range.
  task automatic random_beat();
    logic signed [23:0] s[7];
    int kind, base, slope;
    kind = $urandom_range(9, 0);
    base = $signed(24'($urandom));
    slope = $signed($urandom_range(2000, 0)) - 1000;
    for (int k = 0; k < 7; k++) begin
      if (kind < 6) s[k] = 24'(base / 16 + slope * k * k + $urandom_range(31, 0));
      else s[k] = 24'($urandom);
    end
    send_beat($urandom_range(1, 0), s, $urandom_range(1, 0),
              ($urandom_range(3, 0) == 0) ? 23'($urandom) : 23'($urandom_range(8000, 0)),
              $urandom_range(15, 0) != 0);
  endtask

  initial begin
    logic signed [23:0] s[7];
    sb = new();
    sb.set_reg(REG_MODE_SELECT, RST_MODE_SELECT);
    sb.set_reg(REG_TUBE_HALFWIDTH, RST_TUBE_HALFWIDTH);
    sb.set_reg(REG_INV_SPACING_X, RST_INV_SPACING);
    sb.set_reg(REG_INV_SPACING_Y, RST_INV_SPACING);
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed beats at reset settings: flat, extremes, ramps, inactive nodes.
    s = '{default: 24'sd0};
    send_beat(0, s, 1, 0, 1);
    s = '{24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF,
          24'sh800000, 24'sh7FFFFF};
    send_beat(0, s, 1, 0, 1);
    send_beat(1, s, 0, 0, 1);
    for (int k = 0; k < 7; k++) s[k] = 24'(k * 65536);
    send_beat(0, s, 1, 100, 1);
    send_beat(1, s, 0, 100, 1);
    send_beat(0, s, 1, 100, 0);
    send_beat(0, s, 1, 6554, 1);
    send_beat(0, s, 1, 6553, 1);
    send_beat(0, s, 1, 23'h7FFFFF, 1);
    drain();

    // Both-sided mode with maximal and minimal inverse spacing and maximal band; differences saturate.
    write_reg(REG_MODE_SELECT, 1);
    write_reg(REG_TUBE_HALFWIDTH, 24'h7FFFFF);
    write_reg(REG_INV_SPACING_X, 24'hFFFFFF);
    write_reg(REG_INV_SPACING_Y, 24'd1);
    s = '{24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh000001, 24'sh7FFFFF,
          24'sh800000, 24'sh7FFFFF};
    send_beat(0, s, 1, 23'h7FFFFE, 1);
    send_beat(1, s, 0, 0, 1);
    for (int k = 0; k < 7; k++) s[k] = 24'(k * k * 3000 - 50000);
    send_beat(0, s, 0, 0, 1);
    send_beat(1, s, 1, 0, 1);
    drain();

    // Zero inverse spacing and zero band.
    write_reg(REG_INV_SPACING_X, 24'd0);
    write_reg(REG_TUBE_HALFWIDTH, 24'd0);
    send_beat(0, s, 1, 0, 1);
    drain();
    write_reg(REG_TUBE_HALFWIDTH, 24'd30000);
    send_beat(0, s, 1, 0, 1);
    send_beat(1, s, 1, 0, 1);
    drain();

    // Random phases over several register settings.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_MODE_SELECT, ph % 2);
      write_reg(REG_TUBE_HALFWIDTH, (ph == 5) ? 24'h7FFFFF : 24'($urandom_range(9000, 1)));
      write_reg(REG_INV_SPACING_X, (ph == 2) ? 24'hFFFFFF : 24'($urandom_range(65535, 1)));
      write_reg(REG_INV_SPACING_Y, (ph == 3) ? 24'd1 : 24'($urandom));
      idle_pct = (ph == 1) ? 0 : 24;
      for (int i = 0; i < 270; i++) begin
        random_beat();
        // Hold off once until the pipeline has fully emptied.
        if (ph == 4 && i == 100) drain();
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("weno5_upwind_derivative_tb: PASS");
    end else begin
      $display("weno5_upwind_derivative_tb: FAIL");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #5ms;
    $display("weno5_upwind_derivative_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
